### src/jsu_pkg.sv
// types, codes and helper functions shared by the json string unescape block
// no dependencies
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_BODY = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX  = 3'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_QUOTE    = 3'd1,
    ST_END_ESC     = 3'd2,
    ST_END_UNICODE = 3'd3,
    ST_BAD_HEX     = 3'd4,
    ST_BAD_ESC     = 3'd5,
    ST_UNTERM      = 3'd6
  } status_e;

  localparam logic [7:0]  CH_QUOTE  = 8'h22;
  localparam logic [7:0]  CH_BSLASH = 8'h5C;
  localparam logic [7:0]  CH_SLASH  = 8'h2F;
  localparam logic [7:0]  CH_NUL    = 8'h00;
  localparam logic [7:0]  CH_B      = 8'h62;
  localparam logic [7:0]  CH_F      = 8'h66;
  localparam logic [7:0]  CH_N      = 8'h6E;
  localparam logic [7:0]  CH_R      = 8'h72;
  localparam logic [7:0]  CH_T      = 8'h74;
  localparam logic [7:0]  CH_U      = 8'h75;

  localparam logic [15:0] CP_MAX1   = 16'h007F;
  localparam logic [15:0] CP_MAX2   = 16'h07FF;
  localparam logic [7:0]  LEAD2     = 8'hC0;
  localparam logic [7:0]  LEAD3     = 8'hE0;
  localparam logic [7:0]  CONT      = 8'h80;
  localparam logic [5:0]  CONT_MASK = 6'h3F;

  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_string;
  } in_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] data_byte;
    logic [2:0] status_code;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic [1:0]            cnt;
    out_t [MaxResults-1:0] res;
  } bundle_t;

  // valid flag in bit 4, digit value below
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic out_t make_data(input logic [7:0] b, input logic last);
    out_t r;
    r.is_status   = 1'b0;
    r.data_byte   = b;
    r.status_code = ST_OK;
    r.last_of_run = last;
    return r;
  endfunction

  function automatic out_t make_status(input status_e code);
    out_t r;
    r.is_status   = 1'b1;
    r.data_byte   = 8'd0;
    r.status_code = code;
    r.last_of_run = 1'b1;
    return r;
  endfunction

endpackage

### src/jsu_in_reg.sv
// input register stage of the json string unescape block
// depends on jsu_pkg
module jsu_in_reg import jsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_req_i,
  input  logic adv_i,
  output logic valid_o,
  output in_t  item_o
);

  logic valid_q, valid_d;
  in_t  item_q;
  logic take;

  assign in_ready_o = !valid_q || adv_i;
  assign take       = in_valid_i && in_ready_o;
  assign valid_d    = take ? 1'b1 : (adv_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_req_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### src/jsu_decode.sv
// decoder state and per-byte unescape logic, one byte in, up to three results out
// depends on jsu_pkg
module jsu_decode import jsu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  in_t     item_i,
  input  logic    adv_i,
  output bundle_t bundle_o
);

  mode_e       mode_q, mode_d;
  logic [1:0]  hex_q, hex_d;
  logic [15:0] acc_q, acc_d;
  logic        bad_q, bad_d;

  always_comb begin
    logic [7:0]  b;
    logic [4:0]  nib;
    logic        bad_n;
    logic [15:0] acc_n;
    b        = item_i.in_byte;
    nib      = hex_nibble(b);
    bad_n    = bad_q | ~nib[4];
    acc_n    = nib[4] ? {acc_q[11:0], nib[3:0]} : acc_q;
    mode_d   = mode_q;
    hex_d    = hex_q;
    acc_d    = acc_q;
    bad_d    = bad_q;
    bundle_o = '0;

    if (item_i.start_of_string) begin
      hex_d = 2'd0;
      acc_d = 16'd0;
      bad_d = 1'b0;
      if (b == CH_QUOTE) begin
        mode_d = MODE_BODY;
      end else begin
        mode_d          = MODE_IDLE;
        bundle_o.cnt    = 2'd1;
        bundle_o.res[0] = make_status(ST_NO_QUOTE);
      end
    end else begin
      case (mode_q)
        MODE_BODY: begin
          if (b == CH_NUL) begin
            mode_d          = MODE_IDLE;
            bundle_o.cnt    = 2'd1;
            bundle_o.res[0] = make_status(ST_UNTERM);
          end else if (b == CH_QUOTE) begin
            mode_d          = MODE_IDLE;
            bundle_o.cnt    = 2'd1;
            bundle_o.res[0] = make_status(ST_OK);
          end else if (b == CH_BSLASH) begin
            mode_d = MODE_ESC;
          end else begin
            bundle_o.cnt    = 2'd1;
            bundle_o.res[0] = make_data(b, 1'b1);
          end
        end
        MODE_ESC: begin
          mode_d       = MODE_BODY;
          bundle_o.cnt = 2'd1;
          case (b)
            CH_NUL: begin
              mode_d          = MODE_IDLE;
              bundle_o.res[0] = make_status(ST_END_ESC);
            end
            CH_QUOTE:  bundle_o.res[0] = make_data(CH_QUOTE, 1'b1);
            CH_BSLASH: bundle_o.res[0] = make_data(CH_BSLASH, 1'b1);
            CH_SLASH:  bundle_o.res[0] = make_data(CH_SLASH, 1'b1);
            CH_B:      bundle_o.res[0] = make_data(8'h08, 1'b1);
            CH_F:      bundle_o.res[0] = make_data(8'h0C, 1'b1);
            CH_N:      bundle_o.res[0] = make_data(8'h0A, 1'b1);
            CH_R:      bundle_o.res[0] = make_data(8'h0D, 1'b1);
            CH_T:      bundle_o.res[0] = make_data(8'h09, 1'b1);
            CH_U: begin
              mode_d       = MODE_HEX;
              hex_d        = 2'd0;
              acc_d        = 16'd0;
              bad_d        = 1'b0;
              bundle_o.cnt = 2'd0;
            end
            default: begin
              mode_d          = MODE_IDLE;
              bundle_o.res[0] = make_status(ST_BAD_ESC);
            end
          endcase
        end
        MODE_HEX: begin
          if (b == CH_NUL) begin
            mode_d          = MODE_IDLE;
            bundle_o.cnt    = 2'd1;
            bundle_o.res[0] = make_status(ST_END_UNICODE);
          end else begin
            bad_d = bad_n;
            acc_d = acc_n;
            if (hex_q != 2'd3) begin
              hex_d = hex_q + 2'd1;
            end else begin
              hex_d = 2'd0;
              if (bad_n) begin
                mode_d          = MODE_IDLE;
                bundle_o.cnt    = 2'd1;
                bundle_o.res[0] = make_status(ST_BAD_HEX);
              end else begin
                mode_d = MODE_BODY;
                if (acc_n <= CP_MAX1) begin
                  bundle_o.cnt    = 2'd1;
                  bundle_o.res[0] = make_data(acc_n[7:0], 1'b1);
                end else if (acc_n <= CP_MAX2) begin
                  bundle_o.cnt    = 2'd2;
                  bundle_o.res[0] = make_data(LEAD2 | {3'd0, acc_n[10:6]}, 1'b0);
                  bundle_o.res[1] = make_data(CONT | {2'd0, acc_n[5:0] & CONT_MASK}, 1'b1);
                end else begin
                  bundle_o.cnt    = 2'd3;
                  bundle_o.res[0] = make_data(LEAD3 | {4'd0, acc_n[15:12]}, 1'b0);
                  bundle_o.res[1] = make_data(CONT | {2'd0, acc_n[11:6] & CONT_MASK}, 1'b0);
                  bundle_o.res[2] = make_data(CONT | {2'd0, acc_n[5:0] & CONT_MASK}, 1'b1);
                end
              end
            end
          end
        end
        default: begin
          mode_d = MODE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      hex_q  <= 2'd0;
      acc_q  <= 16'd0;
      bad_q  <= 1'b0;
    end else if (adv_i) begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
      acc_q  <= acc_d;
      bad_q  <= bad_d;
    end
  end

endmodule

### src/jsu_out_buf.sv
// result register holding up to three results of one byte, drained one per cycle while out_ready_i is high
// depends on jsu_pkg
module jsu_out_buf import jsu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  bundle_t bundle_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output out_t    out_req_o
);

  logic [1:0]            cnt_q, cnt_d;
  out_t [MaxResults-1:0] ent_q, ent_d;
  logic                  pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_req_o   = ent_q[0];
  assign pop         = out_valid_o && out_ready_i;
  assign free_o      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  always_comb begin
    cnt_d = cnt_q;
    ent_d = ent_q;
    if (load_i) begin
      cnt_d = bundle_i.cnt;
      ent_d = bundle_i.res;
    end else if (pop) begin
      cnt_d    = cnt_q - 2'd1;
      ent_d[0] = ent_q[1];
      ent_d[1] = ent_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop))
    else $error("result register overwritten while holding results");

  a_one_left_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> ent_q[0].last_of_run)
    else $error("single remaining result not marked last");

  a_two_left_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (ent_q[1].last_of_run && !ent_q[0].last_of_run))
    else $error("last marker misplaced in two remaining results");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.is_status) |-> out_req_o.last_of_run)
    else $error("status result not last of its run");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !load_i && (cnt_q == 2'd1)) |=> !out_valid_o)
    else $error("result register not empty after final pop");
`endif

endmodule

### src/json_string_unescape_utf8_top.sv
// a byte waits in the input register, its decoded results in the result register
// throughput: one byte per cycle while each byte yields at most one result and the receiver is ready
// a \u escape yielding two or three utf-8 bytes stalls the input while the single
// result register, drained one result per cycle while the receiver is ready, empties
// reset: asynchronous, active low; decoder idle, waiting for an opening quote
// top level of the json string unescape block; depends on jsu_pkg and its submodules
module json_string_unescape_utf8_top import jsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_req_o
);

  logic    item_valid;
  in_t     item;
  logic    free;
  logic    adv;
  bundle_t bundle;

  assign adv = item_valid && free;

  jsu_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .adv_i      (adv),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  jsu_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item),
    .adv_i    (adv),
    .bundle_o (bundle)
  );

  jsu_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .bundle_i    (bundle),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

### dv/tb.sv
// testbench for json_string_unescape_utf8_top: directed table, then random strings
// checks every result against the in-bench decoder model or the table's expected result; depends on jsu_pkg and the rtl
module tb;
  import jsu_pkg::*;

  localparam int NDIR        = 31;
  localparam int NRAND       = 330;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;
  localparam int LIMIT       = 400000;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_DATA,
    CHK_STATUS
  } chk_e;

  typedef struct packed {
    logic [7:0] b;
    logic       sos;
    chk_e       chk;
    logic [7:0] dat;
    status_e    code;
  } stim_t;

  localparam stim_t DIR_TAB [NDIR] = '{
    '{8'h41,     1'b0, CHK_NONE,   8'h00, ST_OK},
    '{CH_NUL,    1'b1, CHK_STATUS, 8'h00, ST_NO_QUOTE},
    '{CH_QUOTE,  1'b1, CHK_NONE,   8'h00, ST_OK},
    '{8'h01,     1'b0, CHK_DATA,   8'h01, ST_OK},
    '{8'hFF,     1'b0, CHK_DATA,   8'hFF, ST_OK},
    '{CH_BSLASH, 1'b0, CHK_NONE,   8'h00, ST_OK},
    '{CH_SLASH,  1'b0, CHK_DATA,   8'h2F, ST_OK},
    '{CH_BSLASH, 1'b0, CHK_NONE,   8'h00, ST_OK},
    '{CH_U,      1'b0, CHK_NONE,   8'h00, ST_OK},
    '{8'h46,     1'b0, CHK_NONE,   8'h00, ST_OK},
    '{8'h66,     1'b0, CHK_NONE,   8'h00, ST_OK},
    '{8'h46,     1'b0, CHK_NONE,   8'h00, ST_OK},
    '{8'h66,     1'b0, CHK_MODEL,  8'h00, ST_OK},
    '{CH_QUOTE,  1'b0, CHK_STATUS, 8'h00, ST_OK},
    '{CH_QUOTE,  1'b1, CHK_NONE,   8'h00, ST_OK},
    '{CH_BSLASH, 1'b0, CHK_NONE,   8'h00, ST_OK},
    '{CH_U,      1'b0, CHK_NONE,   8'h00, ST_OK},
    '{CH_QUOTE,  1'b0, CHK_NONE,   8'h00, ST_OK},
    '{8'h31,     1'b0, CHK_NONE,   8'h00, ST_OK},
    '{8'h78,     1'b0, CHK_NONE,   8'h00, ST_OK},
    '{CH_NUL,    1'b0, CHK_STATUS, 8'h00, ST_END_UNICODE},
    '{CH_QUOTE,  1'b1, CHK_NONE,   8'h00, ST_OK},
    '{CH_BSLASH, 1'b0, CHK_NONE,   8'h00, ST_OK},
    '{8'h7A,     1'b0, CHK_STATUS, 8'h00, ST_BAD_ESC},
    '{CH_QUOTE,  1'b1, CHK_NONE,   8'h00, ST_OK},
    '{CH_BSLASH, 1'b0, CHK_NONE,   8'h00, ST_OK},
    '{CH_NUL,    1'b0, CHK_STATUS, 8'h00, ST_END_ESC},
    '{CH_QUOTE,  1'b1, CHK_NONE,   8'h00, ST_OK},
    '{CH_BSLASH, 1'b0, CHK_NONE,   8'h00, ST_OK},
    '{CH_QUOTE,  1'b1, CHK_NONE,   8'h00, ST_OK},
    '{CH_NUL,    1'b0, CHK_STATUS, 8'h00, ST_UNTERM}
  };

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_ready_i = 1'b0;
  in_t  in_req_i    = '0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_req_o;

  stim_t stim_q [$];
  out_t  decoded_q [$];

  mode_e       dec_mode   = MODE_IDLE;
  logic [1:0]  dec_digits = '0;
  logic [15:0] dec_cp     = '0;
  logic        dec_bad    = 1'b0;

  int acc_idx  = 0;
  int sos_cnt  = 0;
  int stat_cnt = 0;
  int data_cnt = 0;
  int err_cnt  = 0;
  int cyc      = 0;
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;

  always #6 clk_i = ~clk_i;

  json_string_unescape_utf8_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o)
  );

  function automatic out_t data_word(input logic [7:0] b, input logic last);
    out_t w;
    w.is_status   = 1'b0;
    w.data_byte   = b;
    w.status_code = ST_OK;
    w.last_of_run = last;
    return w;
  endfunction

  function automatic out_t status_word(input status_e c);
    out_t w;
    w.is_status   = 1'b1;
    w.data_byte   = 8'h00;
    w.status_code = c;
    w.last_of_run = 1'b1;
    return w;
  endfunction

  function automatic logic hex_digit(input logic [7:0] b, output logic [3:0] v);
    v = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = 4'(b - 8'h61 + 8'd10);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = 4'(b - 8'h41 + 8'd10);
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // advances the decoder by one byte, returns the number of results
  function automatic int unescape_step(input logic [7:0] b, input logic sos,
                                       output out_t [MaxResults-1:0] res);
    int n;
    logic stat;
    status_e code;
    logic [3:0] v;
    n = 0;
    stat = 1'b0;
    code = ST_OK;
    res = '0;
    if (sos) begin
      dec_digits = '0;
      dec_cp = '0;
      dec_bad = 1'b0;
      if (b == CH_QUOTE) begin
        dec_mode = MODE_BODY;
      end else begin
        stat = 1'b1;
        code = ST_NO_QUOTE;
      end
    end else begin
      case (dec_mode)
        MODE_BODY: begin
          if (b == CH_NUL) begin
            stat = 1'b1;
            code = ST_UNTERM;
          end else if (b == CH_QUOTE) begin
            stat = 1'b1;
            code = ST_OK;
          end else if (b == CH_BSLASH) begin
            dec_mode = MODE_ESC;
          end else begin
            res[0] = data_word(b, 1'b0);
            n = 1;
          end
        end
        MODE_ESC: begin
          dec_mode = MODE_BODY;
          n = 1;
          case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: res[0] = data_word(b, 1'b0);
            CH_B: res[0] = data_word(8'h08, 1'b0);
            CH_F: res[0] = data_word(8'h0C, 1'b0);
            CH_N: res[0] = data_word(8'h0A, 1'b0);
            CH_R: res[0] = data_word(8'h0D, 1'b0);
            CH_T: res[0] = data_word(8'h09, 1'b0);
            CH_U: begin
              n = 0;
              dec_mode = MODE_HEX;
              dec_digits = '0;
              dec_cp = '0;
              dec_bad = 1'b0;
            end
            CH_NUL: begin
              n = 0;
              stat = 1'b1;
              code = ST_END_ESC;
            end
            default: begin
              n = 0;
              stat = 1'b1;
              code = ST_BAD_ESC;
            end
          endcase
        end
        MODE_HEX: begin
          if (b == CH_NUL) begin
            stat = 1'b1;
            code = ST_END_UNICODE;
          end else begin
            if (hex_digit(b, v)) dec_cp = {dec_cp[11:0], v};
            else dec_bad = 1'b1;
            if (dec_digits != 2'd3) begin
              dec_digits = dec_digits + 2'd1;
            end else begin
              dec_digits = '0;
              if (dec_bad) begin
                stat = 1'b1;
                code = ST_BAD_HEX;
              end else begin
                dec_mode = MODE_BODY;
                if (dec_cp <= CP_MAX1) begin
                  res[0] = data_word(dec_cp[7:0], 1'b0);
                  n = 1;
                end else if (dec_cp <= CP_MAX2) begin
                  res[0] = data_word(LEAD2 | {3'b0, dec_cp[10:6]}, 1'b0);
                  res[1] = data_word(CONT | {2'b0, dec_cp[5:0]}, 1'b0);
                  n = 2;
                end else begin
                  res[0] = data_word(LEAD3 | {4'b0, dec_cp[15:12]}, 1'b0);
                  res[1] = data_word(CONT | {2'b0, dec_cp[11:6]}, 1'b0);
                  res[2] = data_word(CONT | {2'b0, dec_cp[5:0]}, 1'b0);
                  n = 3;
                end
              end
            end
          end
        end
        default: dec_mode = MODE_IDLE;
      endcase
    end
    if (stat) begin
      res[0] = status_word(code);
      n = 1;
      dec_mode = MODE_IDLE;
    end else if (n > 0) begin
      res[n-1].last_of_run = 1'b1;
    end
    return n;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] r;
    logic [3:0] v;
    case ($urandom_range(0, 3))
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      default: begin
        do r = 8'($urandom_range(1, 255)); while (hex_digit(r, v));
        return r;
      end
    endcase
  endfunction

  task automatic put(input logic [7:0] b, input logic sos);
    stim_t s;
    s.b = b;
    s.sos = sos;
    s.chk = CHK_MODEL;
    s.dat = '0;
    s.code = ST_OK;
    stim_q.push_back(s);
  endtask

  task automatic put_plain();
    logic [7:0] r;
    do r = 8'($urandom_range(1, 255)); while (r == CH_QUOTE || r == CH_BSLASH);
    put(r, 1'b0);
  endtask

  task automatic put_escape();
    put(CH_BSLASH, 1'b0);
    case ($urandom_range(0, 7))
      0: put(CH_QUOTE, 1'b0);
      1: put(CH_BSLASH, 1'b0);
      2: put(CH_SLASH, 1'b0);
      3: put(CH_B, 1'b0);
      4: put(CH_F, 1'b0);
      5: put(CH_N, 1'b0);
      6: put(CH_R, 1'b0);
      default: put(CH_T, 1'b0);
    endcase
  endtask

  // fault 0: clean, 1: one bad digit, 2: zero byte at some position, earlier digits may be non-hex
  task automatic put_unicode(input int fault);
    logic [15:0] cp;
    logic [7:0] c;
    int pos;
    case ($urandom_range(0, 3))
      0: cp = 16'($urandom_range(0, 'h7F));
      1: cp = 16'($urandom_range('h80, 'h7FF));
      2: cp = 16'($urandom_range('h800, 'hFFFF));
      default: begin
        case ($urandom_range(0, 5))
          0: cp = 16'h0000;
          1: cp = 16'h007F;
          2: cp = 16'h0080;
          3: cp = 16'h07FF;
          4: cp = 16'h0800;
          default: cp = 16'hFFFF;
        endcase
      end
    endcase
    pos = $urandom_range(0, 3);
    put(CH_BSLASH, 1'b0);
    put(CH_U, 1'b0);
    for (int k = 0; k < 4; k++) begin
      if (fault == 2 && k == pos) begin
        put(CH_NUL, 1'b0);
        return;
      end
      c = hex_char(cp[15-4*k -: 4], 1'($urandom_range(0, 1)));
      if ((fault == 1 && k == pos) || (fault == 2 && $urandom_range(0, 2) == 0)) begin
        c = non_hex_byte();
      end
      put(c, 1'b0);
    end
  endtask

  task automatic put_string();
    int e;
    logic [7:0] r;
    put(CH_QUOTE, 1'b1);
    repeat ($urandom_range(0, 6)) begin
      e = $urandom_range(0, 9);
      if (e < 5) put_plain();
      else if (e < 7) put_escape();
      else put_unicode(0);
    end
    e = $urandom_range(0, 99);
    if (e < 55) begin
      put(CH_QUOTE, 1'b0);
    end else if (e < 62) begin
      put(CH_NUL, 1'b0);
    end else if (e < 69) begin
      put(CH_BSLASH, 1'b0);
      put(CH_NUL, 1'b0);
    end else if (e < 77) begin
      put(CH_BSLASH, 1'b0);
      do r = 8'($urandom_range(1, 255));
      while (r inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
      put(r, 1'b0);
    end else if (e < 85) begin
      put_unicode(2);
    end else if (e < 93) begin
      put_unicode(1);
    end else if (e < 97) begin
      put(CH_BSLASH, 1'b0);
    end
  endtask

  task automatic put_noise();
    repeat ($urandom_range(1, 4)) begin
      put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 2) == 0));
    end
  endtask

  task automatic flag_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 30) $display("mismatch at cycle %0d: %s", cyc, msg);
  endtask

  always @(posedge clk_i) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("timeout with %0d results outstanding", decoded_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // accepted requests feed the model
  always @(posedge clk_i) begin
    stim_t s;
    out_t [MaxResults-1:0] res;
    int n;
    if (rst_ni && in_valid_i && in_ready_o) begin
      s = stim_q[acc_idx];
      acc_idx++;
      if (s.sos) sos_cnt++;
      n = unescape_step(s.b, s.sos, res);
      case (s.chk)
        CHK_MODEL: for (int k = 0; k < n; k++) decoded_q.push_back(res[k]);
        CHK_DATA: decoded_q.push_back(data_word(s.dat, 1'b1));
        CHK_STATUS: decoded_q.push_back(status_word(s.code));
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    out_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (out_req_o.is_status) stat_cnt++;
      else data_cnt++;
      if (decoded_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h", out_req_o));
      end else begin
        w = decoded_q.pop_front();
        if (out_req_o.is_status !== w.is_status)
          flag_mismatch($sformatf("is_status %b, want %b", out_req_o.is_status, w.is_status));
        if (out_req_o.data_byte !== w.data_byte)
          flag_mismatch($sformatf("data_byte %h, want %h", out_req_o.data_byte, w.data_byte));
        if (out_req_o.status_code !== w.status_code)
          flag_mismatch($sformatf("status_code %0d, want %0d",
                                  out_req_o.status_code, w.status_code));
        if (out_req_o.last_of_run !== w.last_of_run)
          flag_mismatch($sformatf("last_of_run %b, want %b",
                                  out_req_o.last_of_run, w.last_of_run));
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (stall == 0 && !quiet) begin
        stall = pick_gap();
      end
      out_ready_i <= (stall == 0);
      if (stall > 0) stall--;
    end
  end

  initial begin
    int gap;
    bit drain;
    for (int i = 0; i < NDIR; i++) stim_q.push_back(DIR_TAB[i]);
    while (stim_q.size() < NDIR + NRAND) begin
      if ($urandom_range(0, 9) == 0) put_noise();
      else put_string();
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < stim_q.size(); i++) begin
      quiet = ((i / 40) % 5 == 2);
      drain = (i == NDIR || i == NDIR + 200);
      gap = pick_gap();
      if (drain || gap > 0) begin
        in_valid_i <= 1'b0;
        if (drain) begin
          @(posedge clk_i);
          while (decoded_q.size() != 0) @(posedge clk_i);
          repeat (SETTLE) @(posedge clk_i);
        end
        repeat (gap) @(posedge clk_i);
      end
      if (i == NDIR + 120) hold_req = 1'b1;
      in_valid_i <= 1'b1;
      in_req_i.in_byte <= stim_q[i].b;
      in_req_i.start_of_string <= stim_q[i].sos;
      do @(posedge clk_i); while (!in_ready_o);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("sent %0d bytes in %0d restarts; checked %0d data bytes and %0d status words",
             acc_idx, sos_cnt, data_cnt, stat_cnt);
    $display("%0d mismatches over %0d cycles", err_cnt, cyc);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
